/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the turn angle unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SABV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define SABV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/sabv_pkg.sv */
// ----------------------------------------------------------------------------
// sabv_pkg
// Constants, types and elaboration-time helpers for the turn angle unit.
// ----------------------------------------------------------------------------
package sabv_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STAGES_DEF   = 14;

    // CORDIC datapath: coordinates scaled to bit 60, growth stays below 2^61
    localparam int CORDIC_SCALE = 60;
    localparam int XY_W         = 62;

    localparam int TURN_W = 16;
    localparam int TOL_W  = 10;
    localparam logic [TOL_W-1:0] TOL_RESET = 10'd82;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint ATAN_Q30 [10] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149
    };

    // quadrant information for both vectors (index 0 first, 1 second)
    typedef struct packed {
        logic [1:0] x_neg;
        logic [1:0] y_neg;
        logic [1:0] x_zero;
        logic [1:0] y_zero;
    } sabv_side_t;

    // Q30 to FRAC fraction bits, rounded half up
    function automatic longint to_frac(longint q30, int frac);
        int sh;
        sh = 30 - frac;
        return (q30 + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint atan_step(int i, int frac);
        longint q;
        if (i < 10) begin
            q = ATAN_Q30[i];
        end else begin
            q = longint'(1) <<< (30 - i);
        end
        return to_frac(q, frac);
    endfunction

endpackage

/* sv/signed_angle_between_vectors_unit.sv */
// ----------------------------------------------------------------------------
// signed_angle_between_vectors_unit
// Signed turn angle from a first to a second screen-space vector, Q3.13
// radians in (-pi, pi], with a snap to +pi/2 near a right angle.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_first_x s_first_y s_second_x s_second_y
// m_       out  m_valid/m_ready    m_turn_angle
// cfg      in   cfg_wr_en          cfg_wr_data (right_angle_tolerance)
//
// One transfer per cycle sustained while m_ready is high, through one entry
// stage, one cell per CORDIC iteration and four finishing stages.
// Ready ripples back through the stage valid bits; an empty stage fills
// even while the output is stalled. Reset empties the pipeline and sets
// the tolerance to 82.
// ----------------------------------------------------------------------------
module signed_angle_between_vectors_unit #(
    parameter int COORD_WIDTH     = sabv_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = sabv_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = sabv_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_WIDTH-1:0]      s_first_x,
    input  logic signed [COORD_WIDTH-1:0]      s_first_y,
    input  logic signed [COORD_WIDTH-1:0]      s_second_x,
    input  logic signed [COORD_WIDTH-1:0]      s_second_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [sabv_pkg::TURN_W-1:0] m_turn_angle,
    input  logic                               cfg_wr_en,
    input  logic [sabv_pkg::TOL_W-1:0]         cfg_wr_data
);

    localparam int XW = sabv_pkg::XY_W;
    localparam int AW = ANGLE_FRAC_BITS + 5;

    logic [sabv_pkg::TOL_W-1:0] tol_reg;
    logic [sabv_pkg::TOL_W-1:0] tol_next;

    logic signed [COORD_WIDTH-1:0] x_in  [2];
    logic signed [COORD_WIDTH-1:0] ys_in [2];

    logic                  v_c   [CORDIC_STAGES+1];
    logic                  rdy_c [CORDIC_STAGES+1];
    logic signed [XW-1:0]  x_c   [CORDIC_STAGES+1][2];
    logic signed [XW-1:0]  y_c   [CORDIC_STAGES+1][2];
    logic signed [AW-1:0]  z_c   [CORDIC_STAGES+1][2];
    sabv_pkg::sabv_side_t  side_c [CORDIC_STAGES+1];

    always_comb begin
        tol_next = cfg_wr_en ? cfg_wr_data : tol_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= sabv_pkg::TOL_RESET;
        end else begin
            tol_reg <= tol_next;
        end
    end

    assign x_in[0]  = s_first_x;
    assign x_in[1]  = s_second_x;
    assign ys_in[0] = s_first_y;
    assign ys_in[1] = s_second_y;

    sabv_prep #(
        .CW (COORD_WIDTH),
        .XW (XW)
    ) u_prep (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_in      (x_in),
        .ys_in     (ys_in),
        .out_valid (v_c[0]),
        .out_ready (rdy_c[0]),
        .x_out     (x_c[0]),
        .y_out     (y_c[0]),
        .side_out  (side_c[0])
    );

    assign z_c[0][0] = '0;
    assign z_c[0][1] = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        sabv_cordic_cell #(
            .STAGE (i),
            .XW    (XW),
            .AW    (AW),
            .FRAC  (ANGLE_FRAC_BITS)
        ) u_cell (
            .clk       (aclk),
            .rst_n     (aresetn),
            .in_valid  (v_c[i]),
            .in_ready  (rdy_c[i]),
            .x_in      (x_c[i]),
            .y_in      (y_c[i]),
            .z_in      (z_c[i]),
            .side_in   (side_c[i]),
            .out_valid (v_c[i+1]),
            .out_ready (rdy_c[i+1]),
            .x_out     (x_c[i+1]),
            .y_out     (y_c[i+1]),
            .z_out     (z_c[i+1]),
            .side_out  (side_c[i+1])
        );
    end

    sabv_finish #(
        .AW   (AW),
        .FRAC (ANGLE_FRAC_BITS)
    ) u_finish (
        .clk        (aclk),
        .rst_n      (aresetn),
        .in_valid   (v_c[CORDIC_STAGES]),
        .in_ready   (rdy_c[CORDIC_STAGES]),
        .z_in       (z_c[CORDIC_STAGES]),
        .side_in    (side_c[CORDIC_STAGES]),
        .tol        (tol_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .turn_angle (m_turn_angle)
    );

endmodule

/* sv/sabv_prep.sv */
// ----------------------------------------------------------------------------
// sabv_prep
// Entry stage: flips screen y, takes magnitudes and quadrant flags, and
// scales the magnitudes into the CORDIC datapath.
// ----------------------------------------------------------------------------
module sabv_prep #(
    parameter int CW = sabv_pkg::COORD_WIDTH_DEF,
    parameter int XW = sabv_pkg::XY_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CW-1:0]     x_in  [2],
    input  logic signed [CW-1:0]     ys_in [2],
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [XW-1:0]     x_out [2],
    output logic signed [XW-1:0]     y_out [2],
    output sabv_pkg::sabv_side_t     side_out
);

    localparam int PRE = sabv_pkg::CORDIC_SCALE - CW;

    logic                  valid_reg;
    logic                  valid_next;
    logic signed [XW-1:0]  x_reg [2];
    logic signed [XW-1:0]  y_reg [2];
    logic signed [XW-1:0]  x_next [2];
    logic signed [XW-1:0]  y_next [2];
    sabv_pkg::sabv_side_t  side_reg;
    sabv_pkg::sabv_side_t  side_next;
    logic signed [CW:0]    xe [2];
    logic signed [CW:0]    ye [2];
    logic signed [CW:0]    xa [2];
    logic signed [CW:0]    ya [2];
    logic                  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            xe[k] = (CW+1)'(x_in[k]);
            ye[k] = -((CW+1)'(ys_in[k]));
            xa[k] = xe[k][CW] ? -xe[k] : xe[k];
            ya[k] = ye[k][CW] ? -ye[k] : ye[k];
            x_next[k] = XW'(xa[k]) <<< PRE;
            y_next[k] = XW'(ya[k]) <<< PRE;
            side_next.x_neg[k]  = xe[k][CW];
            side_next.y_neg[k]  = ye[k][CW];
            side_next.x_zero[k] = (xe[k] == '0);
            side_next.y_zero[k] = (ye[k] == '0);
        end
    end

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign side_out  = side_reg;

endmodule

/* sv/sabv_cordic_cell.sv */
// ----------------------------------------------------------------------------
// sabv_cordic_cell
// One vectoring CORDIC iteration for both vectors of an item, registered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sabv_cordic_cell #(
    parameter int STAGE = 0,
    parameter int XW    = sabv_pkg::XY_W,
    parameter int AW    = sabv_pkg::ANGLE_FRAC_BITS_DEF + 5,
    parameter int FRAC  = sabv_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [XW-1:0]     x_in [2],
    input  logic signed [XW-1:0]     y_in [2],
    input  logic signed [AW-1:0]     z_in [2],
    input  sabv_pkg::sabv_side_t     side_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [XW-1:0]     x_out [2],
    output logic signed [XW-1:0]     y_out [2],
    output logic signed [AW-1:0]     z_out [2],
    output sabv_pkg::sabv_side_t     side_out
);

    localparam logic signed [AW-1:0] ATAN = AW'(sabv_pkg::atan_step(STAGE, FRAC));

    logic                  valid_reg;
    logic                  valid_next;
    logic signed [XW-1:0]  x_reg [2];
    logic signed [XW-1:0]  y_reg [2];
    logic signed [AW-1:0]  z_reg [2];
    logic signed [XW-1:0]  x_next [2];
    logic signed [XW-1:0]  y_next [2];
    logic signed [AW-1:0]  z_next [2];
    logic signed [XW-1:0]  dx [2];
    logic signed [XW-1:0]  dy [2];
    sabv_pkg::sabv_side_t  side_reg;
    logic                  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            dx[k] = y_in[k] >>> STAGE;
            dy[k] = x_in[k] >>> STAGE;
            if (!y_in[k][XW-1]) begin
                x_next[k] = x_in[k] + dx[k];
                y_next[k] = y_in[k] - dy[k];
                z_next[k] = z_in[k] + ATAN;
            end else begin
                x_next[k] = x_in[k] - dx[k];
                y_next[k] = y_in[k] + dy[k];
                z_next[k] = z_in[k] - ATAN;
            end
        end
    end

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

    `SABV_ASSERT_NEXT(cell_hold_chk, clk, rst_n, valid_reg && !out_ready, valid_reg && $stable(z_reg[0]) && $stable(z_reg[1]))

endmodule

/* sv/sabv_finish.sv */
// ----------------------------------------------------------------------------
// sabv_finish
// Quadrant mapping, signed difference with wrap, and right-angle snap,
// over four registered stages; the last one is the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sabv_finish #(
    parameter int AW   = sabv_pkg::ANGLE_FRAC_BITS_DEF + 5,
    parameter int FRAC = sabv_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [AW-1:0]               z_in [2],
    input  sabv_pkg::sabv_side_t               side_in,
    input  logic [sabv_pkg::TOL_W-1:0]         tol,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sabv_pkg::TURN_W-1:0] turn_angle
);

    localparam logic signed [AW-1:0] PI =
        AW'(sabv_pkg::to_frac(sabv_pkg::PI_Q30, FRAC));
    localparam logic signed [AW-1:0] HALF_PI =
        AW'(sabv_pkg::to_frac(sabv_pkg::HALF_PI_Q30, FRAC));
    localparam logic signed [AW-1:0] TWO_PI        = PI + PI;
    localparam logic signed [AW-1:0] THREE_HALF_PI = PI + HALF_PI;

    logic [3:0]            v_reg;
    logic [3:0]            v_next;
    logic [3:0]            rdy;
    logic [3:0]            up_valid;

    logic signed [AW-1:0]  zc [2];
    logic signed [AW-1:0]  r [2];
    logic signed [AW-1:0]  a_reg [2];
    logic signed [AW-1:0]  d0;
    logic signed [AW-1:0]  d1_next;
    logic signed [AW-1:0]  d1_reg;
    logic signed [AW-1:0]  d2_next;
    logic signed [AW-1:0]  d2_reg;
    logic signed [AW-1:0]  mag_next;
    logic signed [AW-1:0]  mag_reg;
    logic signed [AW-1:0]  off;
    logic [AW-1:0]         off_mag;
    logic signed [AW-1:0]  out_next;
    logic signed [AW-1:0]  out_reg;

    // stage handshake, bubbles collapse
    assign up_valid = {v_reg[2:0], in_valid};
    assign rdy[3]   = !v_reg[3] || out_ready;
    assign rdy[2]   = !v_reg[2] || rdy[3];
    assign rdy[1]   = !v_reg[1] || rdy[2];
    assign rdy[0]   = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_comb begin
        for (int s = 0; s < 4; s++) begin
            v_next[s] = rdy[s] ? up_valid[s] : v_reg[s];
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // polar angle per vector
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            priority if (z_in[k] < 0) begin
                zc[k] = '0;
            end else if (z_in[k] > HALF_PI) begin
                zc[k] = HALF_PI;
            end else begin
                zc[k] = z_in[k];
            end
            priority if (side_in.x_zero[k] && side_in.y_zero[k]) begin
                r[k] = '0;
            end else if (side_in.x_zero[k]) begin
                r[k] = side_in.y_neg[k] ? THREE_HALF_PI : HALF_PI;
            end else if (side_in.y_zero[k]) begin
                r[k] = side_in.x_neg[k] ? PI : '0;
            end else if (!side_in.x_neg[k] && !side_in.y_neg[k]) begin
                r[k] = zc[k];
            end else if (side_in.x_neg[k] && !side_in.y_neg[k]) begin
                r[k] = PI - zc[k];
            end else if (side_in.x_neg[k] && side_in.y_neg[k]) begin
                r[k] = PI + zc[k];
            end else begin
                r[k] = TWO_PI - zc[k];
                if (r[k] >= TWO_PI) begin
                    r[k] = r[k] - TWO_PI;
                end
            end
        end
    end

    always_comb begin
        d0       = a_reg[1] - a_reg[0];
        d1_next  = d0[AW-1] ? d0 + TWO_PI : d0;
        d2_next  = (d1_reg > PI) ? d1_reg - TWO_PI : d1_reg;
        mag_next = d2_next[AW-1] ? -d2_next : d2_next;
        off      = mag_reg - HALF_PI;
        off_mag  = off[AW-1] ? AW'(-off) : AW'(off);
        out_next = (off_mag < AW'(tol)) ? HALF_PI : d2_reg;
    end

    always_ff @(posedge clk) begin
        if (in_valid && rdy[0]) begin
            a_reg <= r;
        end
        if (up_valid[1] && rdy[1]) begin
            d1_reg <= d1_next;
        end
        if (up_valid[2] && rdy[2]) begin
            d2_reg  <= d2_next;
            mag_reg <= mag_next;
        end
        if (up_valid[3] && rdy[3]) begin
            out_reg <= out_next;
        end
    end

    assign out_valid  = v_reg[3];
    assign turn_angle = sabv_pkg::TURN_W'(out_reg);

    `SABV_ASSERT_IMPLY(polar_range_chk, clk, rst_n, v_reg[0], (a_reg[0] >= 0) && (a_reg[0] < TWO_PI) && (a_reg[1] >= 0) && (a_reg[1] < TWO_PI))
    `SABV_ASSERT_IMPLY(wrap_range_chk, clk, rst_n, v_reg[2], (d2_reg > -PI) && (d2_reg <= PI) && (mag_reg >= 0))

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Streams vector pairs through the turn angle unit under random back-pressure
// on the output and random input gaps. A bit-accurate CORDIC predictor works
// out each expected turn angle, and every output transfer is checked in order.
// The snap window is changed between phases, with the pipeline drained first.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     COORD_W        = 16;
    localparam int     CORDIC_ITERS   = 14;
    localparam int     COORD_SHIFT    = 60 - COORD_W;
    localparam int     PIPE_LATENCY   = CORDIC_ITERS + 5;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     FRAC_SHIFT     = 30 - 13;
    localparam longint HALF_LSB_Q30   = 64'sd1 <<< (FRAC_SHIFT - 1);
    localparam longint PI_ANG         = (64'sd3373259426 + HALF_LSB_Q30) >>> FRAC_SHIFT;
    localparam longint HALF_PI_ANG    = (64'sd1686629713 + HALF_LSB_Q30) >>> FRAC_SHIFT;
    localparam longint TWO_PI_ANG     = 2 * PI_ANG;
    localparam longint ARCTAN_Q30 [10] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149
    };

    typedef logic signed [COORD_W-1:0]          coord_t;
    typedef logic signed [sabv_pkg::TURN_W-1:0] turn_t;

    class turn_angle_scoreboard;
        logic [sabv_pkg::TOL_W-1:0] tolerance = 10'd82;
        turn_t pending_turns[$];
        int    mismatches = 0;

        function longint arctan_lsb(int i);
            longint q;
            q = (i < 10) ? ARCTAN_Q30[i] : (64'sd1 <<< (30 - i));
            return (q + HALF_LSB_Q30) >>> FRAC_SHIFT;
        endfunction

        // vectoring CORDIC on (ax, ay), both strictly positive
        function longint quadrant_angle(longint ax, longint ay);
            longint x, y, z, dx, dy;
            int i;
            x = ax <<< COORD_SHIFT;
            y = ay <<< COORD_SHIFT;
            z = 0;
            for (i = 0; i < CORDIC_ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_lsb(i);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_lsb(i);
                end
            end
            if (z < 0) z = 0;
            if (z > HALF_PI_ANG) z = HALF_PI_ANG;
            return z;
        endfunction

        // polar angle in [0, 2pi); screen y is flipped first
        function longint polar_angle(coord_t cx, coord_t cy);
            longint x, y, a, r;
            x = longint'(cx);
            y = -longint'(cy);
            if (x == 0 && y == 0) return 0;
            if (x == 0) return (y > 0) ? HALF_PI_ANG : PI_ANG + HALF_PI_ANG;
            if (y == 0) return (x > 0) ? 0 : PI_ANG;
            a = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
            if (x > 0 && y > 0)      r = a;
            else if (x < 0 && y > 0) r = PI_ANG - a;
            else if (x < 0)          r = PI_ANG + a;
            else                     r = TWO_PI_ANG - a;
            if (r >= TWO_PI_ANG) r = r - TWO_PI_ANG;
            return r;
        endfunction

        function turn_t predict_turn_angle(coord_t fx, coord_t fy, coord_t sx, coord_t sy);
            longint a1, a2, d, off;
            a1 = polar_angle(fx, fy);
            a2 = polar_angle(sx, sy);
            if (a2 < a1) a2 = a2 + TWO_PI_ANG;
            d = a2 - a1;
            if (d > PI_ANG) d = d - TWO_PI_ANG;
            off = (d < 0 ? -d : d) - HALF_PI_ANG;
            if (off < 0) off = -off;
            if (off < longint'(tolerance)) d = HALF_PI_ANG;
            return turn_t'(d);
        endfunction

        function void note_vector_pair(coord_t fx, coord_t fy, coord_t sx, coord_t sy);
            pending_turns.push_back(predict_turn_angle(fx, fy, sx, sy));
        endfunction

        function void check_turn_angle(turn_t actual);
            turn_t want;
            if (pending_turns.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transfer: turn_angle %0d", actual);
                return;
            end
            want = pending_turns.pop_front();
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("turn_angle mismatch: expected %0d, got %0d", want, actual);
            end
        endfunction
    endclass

    logic   aclk        = 1'b0;
    logic   aresetn     = 1'b0;
    logic   s_valid     = 1'b0;
    logic   s_ready;
    coord_t s_first_x   = '0;
    coord_t s_first_y   = '0;
    coord_t s_second_x  = '0;
    coord_t s_second_y  = '0;
    logic   m_valid;
    logic   m_ready     = 1'b0;
    turn_t  m_turn_angle;
    logic   cfg_wr_en   = 1'b0;
    logic [sabv_pkg::TOL_W-1:0] cfg_wr_data = '0;

    bit steady = 1'b0;
    int quiet_cycles = 0;
    turn_angle_scoreboard sb;

    signed_angle_between_vectors_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_first_x    (s_first_x),
        .s_first_y    (s_first_y),
        .s_second_x   (s_second_x),
        .s_second_y   (s_second_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_turn_angle (m_turn_angle),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return coord_t'($urandom_range(0, 6) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh8001;
                    default: return 16'sh0000;
                endcase
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_vector_pair(s_first_x, s_first_y, s_second_x, s_second_y);
            if (m_valid && m_ready)
                sb.check_turn_angle(m_turn_angle);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : result_sink
        int low_left;
        int high_left;
        low_left  = 0;
        high_left = 0;
        forever begin
            @(negedge aclk);
            if (!steady && low_left == 0 && high_left == 0) begin
                low_left  = pick_gap();
                high_left = $urandom_range(1, 12);
            end
            if (steady) begin
                m_ready <= 1'b1;
            end else if (low_left > 0) begin
                m_ready <= 1'b0;
                low_left--;
            end else begin
                m_ready <= 1'b1;
                high_left--;
            end
        end
    end

    task automatic send_pair(coord_t fx, coord_t fy, coord_t sx, coord_t sy);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_first_x  <= fx;
        s_first_y  <= fy;
        s_second_x <= sx;
        s_second_y <= sy;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (sb.pending_turns.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [sabv_pkg::TOL_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.tolerance = value;
    endtask

    task automatic run_random(int count, int pause_at);
        coord_t fx, fy, sx, sy;
        int n;
        for (n = 0; n < count; n++) begin
            if (n == pause_at) begin
                stop_sender();
                while (sb.pending_turns.size() != 0) @(posedge aclk);
            end
            fx = pick_coord();
            fy = pick_coord();
            if ($urandom_range(0, 3) == 0) begin
                // roughly perpendicular pair, exercises the snap window
                sx = coord_t'(-int'(fy) + $urandom_range(0, 600) - 300);
                sy = coord_t'(int'(fx) + $urandom_range(0, 600) - 300);
            end else begin
                sx = pick_coord();
                sy = pick_coord();
            end
            send_pair(fx, fy, sx, sy);
        end
        stop_sender();
    endtask

    initial begin
        sb = new;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 5, 0);
        send_pair(1, 0, 0, -1);
        send_pair(1, 0, 0, 1);
        send_pair(1, 0, -1, 0);
        send_pair(-1, 0, 1, 0);
        send_pair(0, -7, 0, 7);
        send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 0, 0, 16'sh8000);
        send_pair(16'sh7fff, 1, 16'sh7fff, -1);
        send_pair(16'sh7fff, -1, 16'sh7fff, 1);
        send_pair(1, 1, -1, -1);
        send_pair(-1, -1, 1, 1);
        send_pair(100, 3, 3, -100);
        send_pair(100, 3, -3, 100);
        send_pair(1, 16'sh8000, 16'sh7fff, -1);
        send_pair(16'sh8000, -1, 16'sh8000, 1);
        send_pair(12345, -6789, -4321, 9876);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(-16'sh5555, 16'sh2aaa, 16'sh5555, -16'sh2aaa);
        stop_sender();
        run_random(380, -1);

        drain_results();
        write_tolerance(10'd0);
        run_random(400, 200);

        drain_results();
        write_tolerance(10'd1023);
        steady = 1'b1;
        run_random(150, -1);
        steady = 1'b0;
        run_random(250, -1);

        drain_results();
        write_tolerance(10'($urandom_range(1, 1022)));
        run_random(400, 120);

        drain_results();
        write_tolerance(10'd82);
        run_random(400, -1);

        drain_results();
        if (sb.mismatches == 0 && sb.pending_turns.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/sabv_pkg.sv
sv/sabv_prep.sv
sv/sabv_cordic_cell.sv
sv/sabv_finish.sv
sv/signed_angle_between_vectors_unit.sv
tb/tb_top.sv
